// ===== rtl/midi_byte_stream_parser_core_defines.svh =====
// Assertion macros for the MIDI byte stream parser.
`ifndef MIDI_BYTE_STREAM_PARSER_CORE_DEFINES_SVH
`define MIDI_BYTE_STREAM_PARSER_CORE_DEFINES_SVH

`ifndef SYNTH
`define MBSP_ASSERT(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("mbsp assertion failed");
`define MBSP_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("mbsp assertion failed");
`else
`define MBSP_ASSERT(label, expr)
`define MBSP_ASSERT_NEXT(label, pre, post)
`endif

`endif

// ===== rtl/mbsp_pkg.sv =====
`timescale 1ns / 1ps
package mbsp_pkg;

	localparam int LEN_BITS = 16;
	localparam logic [LEN_BITS-1:0] LEN_MAX = 16'hffff;

	localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
	localparam logic [7:0] ST_NOTE_ON   = 8'h90;
	localparam logic [7:0] ST_SYSEX     = 8'hf0;
	localparam logic [7:0] ST_SYSEX_END = 8'hf7;
	localparam logic [7:0] NIB_MASK     = 8'h0f;
	localparam logic [7:0] VEL_DEFAULT  = 8'h40;
	localparam logic [3:0] HI_PROG      = 4'hc;
	localparam logic [3:0] HI_PRESS     = 4'hd;

	typedef enum logic [2:0] {
		KIND_CHAN   = 3'd0,
		KIND_SXDATA = 3'd1,
		KIND_SXEND  = 3'd2,
		KIND_RT     = 3'd3,
		KIND_ERR    = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		PH_STATUS = 4'b0001,
		PH_FIRST  = 4'b0010,
		PH_SECOND = 4'b0100,
		PH_SYSEX  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0] status;
		phase_t     phase;
		logic [7:0] first;
	} parse_state_t;

	typedef struct packed {
		logic [LEN_BITS-1:0] sysex_length;
		logic [7:0]          data_b;
		logic [7:0]          data_a;
		logic [3:0]          channel;
		logic [7:0]          opcode;
		kind_t               kind;
	} result_t;

endpackage

// ===== rtl/mbsp_decode.sv =====
`timescale 1ns / 1ps
module mbsp_decode
	import mbsp_pkg::*;
#(
	parameter int SYSEX_COUNT_BITS = 16
) (
	input  logic [7:0]                  in_byte,
	input  parse_state_t                st,
	input  logic [SYSEX_COUNT_BITS-1:0] count,
	output parse_state_t                nxt,
	output logic [SYSEX_COUNT_BITS-1:0] nxt_count,
	output logic                        emit,
	output result_t                     res
);

	logic        one_data;
	logic [7:0]  opc_hi;
	logic [31:0] count_ext;

	assign one_data  = (st.status[7:4] == HI_PROG) || (st.status[7:4] == HI_PRESS);
	assign opc_hi    = st.status & ~NIB_MASK;
	assign count_ext = 32'(count);

	always_comb begin
		nxt              = st;
		nxt_count        = count;
		emit             = 1'b0;
		res.kind         = KIND_CHAN;
		res.opcode       = '0;
		res.channel      = '0;
		res.data_a       = '0;
		res.data_b       = '0;
		res.sysex_length = '0;
		unique case (st.phase)
			PH_SYSEX: begin
				emit       = 1'b1;
				res.opcode = ST_SYSEX;
				if (in_byte == ST_SYSEX_END) begin
					res.kind         = KIND_SXEND;
					res.sysex_length = (count_ext > 32'(LEN_MAX)) ? LEN_MAX
						: count_ext[LEN_BITS-1:0];
					nxt.phase        = PH_STATUS;
					nxt_count        = '0;
				end else begin
					res.kind   = KIND_SXDATA;
					res.data_a = in_byte;
					if (count != '1) begin
						nxt_count = count + 1'b1;
					end
				end
			end
			PH_SECOND: begin
				emit        = 1'b1;
				res.kind    = KIND_CHAN;
				res.channel = st.status[3:0];
				res.data_a  = st.first;
				nxt.phase   = PH_STATUS;
				if (opc_hi == ST_NOTE_ON && in_byte == 8'h00) begin
					res.opcode = ST_NOTE_OFF;
					res.data_b = VEL_DEFAULT;
				end else begin
					res.opcode = opc_hi;
					res.data_b = in_byte;
				end
			end
			PH_FIRST, PH_STATUS: begin
				if (st.phase == PH_STATUS && in_byte[7]) begin
					if (in_byte < ST_SYSEX) begin
						nxt.status = in_byte;
						nxt.phase  = PH_FIRST;
					end else begin
						nxt.status = '0;
						if (in_byte == ST_SYSEX) begin
							nxt.phase = PH_SYSEX;
							nxt_count = '0;
						end else begin
							emit        = 1'b1;
							res.kind    = (in_byte <= ST_SYSEX_END) ? KIND_ERR : KIND_RT;
							res.opcode  = in_byte;
							res.channel = in_byte[3:0];
						end
					end
				end else if (st.phase == PH_FIRST || st.status[7]) begin
					if (one_data) begin
						emit        = 1'b1;
						res.kind    = KIND_CHAN;
						res.opcode  = opc_hi;
						res.channel = st.status[3:0];
						res.data_a  = in_byte;
						nxt.phase   = PH_STATUS;
					end else begin
						nxt.first = in_byte;
						nxt.phase = PH_SECOND;
					end
				end else begin
					emit       = 1'b1;
					res.kind   = KIND_ERR;
					res.data_a = in_byte;
				end
			end
			default: begin
				nxt.phase = PH_STATUS;
			end
		endcase
	end

endmodule

// ===== rtl/midi_byte_stream_parser_core.sv =====
// MIDI byte stream parser with running status.
// A byte is registered in the input stage and any result in the result buffer.
// Throughput: one byte per cycle unless the result buffer is full; a two-entry
// result buffer keeps input flowing while a result waits to be taken.
// Reset: arst_n clears the parse state, the input stage and the result buffer.
`timescale 1ns / 1ps
`include "midi_byte_stream_parser_core_defines.svh"
module midi_byte_stream_parser_core
	import mbsp_pkg::*;
#(
	parameter int SYSEX_COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // in_byte[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// opcode[7:0], channel[11:8], data_a[19:12], data_b[27:20],
	// sysex_length[43:28], zero[47:44]
	output logic [47:0] m_tdata,
	output logic [2:0]  m_tuser   // kind[2:0]
);

	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	parse_state_t                st_q;
	parse_state_t                st_nxt;
	logic [SYSEX_COUNT_BITS-1:0] count_q;
	logic [SYSEX_COUNT_BITS-1:0] count_nxt;
	logic                        emit;
	result_t                     res;

	result_t    buf_q [2];
	logic       rd_ptr_q;
	logic       wr_ptr_q;
	logic [1:0] cnt_q;
	logic       full;
	logic       consume;
	logic       push;
	logic       pop;
	result_t    head;

	assign full     = (cnt_q == 2'd2);
	assign consume  = valid_s1 && !full;
	assign s_tready = !valid_s1 || consume;
	assign push     = consume && emit;
	assign pop      = m_tvalid && m_tready;

	mbsp_decode #(
		.SYSEX_COUNT_BITS(SYSEX_COUNT_BITS)
	) u_decode (
		.in_byte   (byte_s1),
		.st        (st_q),
		.count     (count_q),
		.nxt       (st_nxt),
		.nxt_count (count_nxt),
		.emit      (emit),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// advance parse state on each consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.status <= '0;
			st_q.phase  <= PH_STATUS;
			st_q.first  <= '0;
			count_q     <= '0;
		end else if (consume) begin
			st_q    <= st_nxt;
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= res;
		end
	end

	assign head     = buf_q[rd_ptr_q];
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tuser  = head.kind;
	assign m_tdata  = {4'b0000, head.sysex_length, head.data_b, head.data_a,
		head.channel, head.opcode};

	`MBSP_ASSERT(a_buf_bound, cnt_q != 2'd3)
	`MBSP_ASSERT(a_sysex_no_status, st_q.phase != PH_SYSEX || st_q.status == 8'h00)
	`MBSP_ASSERT(a_second_has_status, st_q.phase != PH_SECOND || st_q.status[7])
	`MBSP_ASSERT_NEXT(a_hold_s1, valid_s1 && !consume, valid_s1 && $stable(byte_s1))

endmodule
